FILE: rtl/vbanp_pkg.sv
// Shared types and constants for the VBAN audio packetizer.
package vbanp_pkg;

	localparam int unsigned HEADER_BYTES = 28;
	localparam int unsigned NAME_BYTES   = 16;

	localparam logic [7:0] CHAR_V = 8'h56;
	localparam logic [7:0] CHAR_B = 8'h42;
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_N = 8'h4e;

	localparam logic OP_AUDIO = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [2:0] REG_RATE_SEL       = 3'd0;
	localparam logic [2:0] REG_SAMPLE_FORMAT  = 3'd1;
	localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd2;
	localparam logic [2:0] REG_FRAMES_PER_PKT = 3'd3;
	localparam logic [2:0] REG_NAME_LOW       = 3'd4;
	localparam logic [2:0] REG_NAME_HIGH      = 3'd5;

	localparam logic [4:0] HDR_IDX_V      = 5'd0;
	localparam logic [4:0] HDR_IDX_B      = 5'd1;
	localparam logic [4:0] HDR_IDX_A      = 5'd2;
	localparam logic [4:0] HDR_IDX_N      = 5'd3;
	localparam logic [4:0] HDR_IDX_RATE   = 5'd4;
	localparam logic [4:0] HDR_IDX_FRAMES = 5'd5;
	localparam logic [4:0] HDR_IDX_CHANS  = 5'd6;
	localparam logic [4:0] HDR_IDX_FORMAT = 5'd7;
	localparam logic [4:0] HDR_IDX_NAME   = 5'd8;
	localparam logic [4:0] HDR_IDX_COUNT  = 5'd24;
	localparam logic [4:0] HDR_IDX_DONE   = 5'd28;

	typedef struct packed {
		logic       op;
		logic [7:0] audio_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       packet_abort;
		logic       run_end;
	} out_t;

	typedef struct packed {
		logic [4:0]              rate_sel;
		logic [7:0]              frames_m1;
		logic [2:0]              channels_m1;
		logic [1:0]              sample_format;
		logic [NAME_BYTES*8-1:0] name_bytes;
		logic [31:0]             counter;
	} hdr_fields_t;

endpackage

FILE: rtl/vbanp_geometry.sv
// Effective frame and channel counts and payload length from the configuration.
module vbanp_geometry import vbanp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_BYTES = 1436,
	parameter int unsigned MAX_FRAMES        = 256,
	parameter int unsigned LEN_W             = 11
) (
	input  logic [1:0]       sample_format,
	input  logic [3:0]       channel_count,
	input  logic [8:0]       frames_per_packet,
	output logic [7:0]       frames_m1,
	output logic [2:0]       channels_m1,
	output logic [LEN_W-1:0] payload_len
);

	localparam int unsigned CMP_W = (LEN_W > 9) ? LEN_W : 9;

	logic [LEN_W-1:0] lim_tbl [32];
	logic [3:0]       chans;
	logic [2:0]       bps;
	logic [5:0]       bpf;
	logic [4:0]       bpf_m1;
	logic [8:0]       frames_a;
	logic [8:0]       frames_b;
	logic [8:0]       frames_c;
	logic [8:0]       frames_eff;
	logic [LEN_W-1:0] lim;
	logic [14:0]      len_full;

	for (genvar g = 0; g < 32; g++) begin : g_lim
		localparam int unsigned LIMV = MAX_PAYLOAD_BYTES / (g + 1);
		assign lim_tbl[g] = LEN_W'(LIMV);
	end

	always_comb begin
		if (channel_count == 4'd0) begin
			chans = 4'd1;
		end else if (channel_count > 4'd8) begin
			chans = 4'd8;
		end else begin
			chans = channel_count;
		end
		bps    = {1'b0, sample_format} + 3'd1;
		bpf    = {2'b00, chans} * {3'b000, bps};
		bpf_m1 = 5'(bpf - 6'd1);
		lim    = lim_tbl[bpf_m1];

		frames_a = (frames_per_packet == 9'd0) ? 9'd1 : frames_per_packet;
		frames_b = (frames_a > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES) : frames_a;
		frames_c = (CMP_W'(frames_b) > CMP_W'(lim)) ? 9'(lim) : frames_b;
		frames_eff = (frames_c == 9'd0) ? 9'd1 : frames_c;

		len_full    = frames_eff * bpf;
		payload_len = LEN_W'(len_full);
		frames_m1   = 8'(frames_eff - 9'd1);
		channels_m1 = 3'(chans - 4'd1);
	end

endmodule

FILE: rtl/vbanp_header.sv
// Header byte selection by position within the 28-byte VBAN header.
module vbanp_header import vbanp_pkg::*; (
	input  hdr_fields_t fields,
	input  logic [4:0]  idx,
	output logic [7:0]  hdr_byte
);

	logic [3:0] name_idx;

	always_comb begin
		name_idx = 4'(idx - HDR_IDX_NAME);
		unique case (idx)
			HDR_IDX_V: begin
				hdr_byte = CHAR_V;
			end
			HDR_IDX_B: begin
				hdr_byte = CHAR_B;
			end
			HDR_IDX_A: begin
				hdr_byte = CHAR_A;
			end
			HDR_IDX_N: begin
				hdr_byte = CHAR_N;
			end
			HDR_IDX_RATE: begin
				hdr_byte = {3'b000, fields.rate_sel};
			end
			HDR_IDX_FRAMES: begin
				hdr_byte = fields.frames_m1;
			end
			HDR_IDX_CHANS: begin
				hdr_byte = {5'b00000, fields.channels_m1};
			end
			HDR_IDX_FORMAT: begin
				hdr_byte = {6'b000000, fields.sample_format};
			end
			default: begin
				if (idx < HDR_IDX_COUNT) begin
					hdr_byte = fields.name_bytes[{name_idx, 3'b000} +: 8];
				end else begin
					hdr_byte = fields.counter[{idx[1:0], 3'b000} +: 8];
				end
			end
		endcase
	end

endmodule

FILE: rtl/vban_audio_packetizer_top.sv
// Top level of the VBAN audio packetizer: input stage, framing control, output register.
//
// Audio bytes and flush commands enter on the in_valid/in_ready channel, one per
// transaction. Packet bytes leave on out_valid/out_ready, one per transaction.
// The first audio byte of a packet produces the 28 header bytes and then itself;
// every other audio byte produces one byte. A flush produces one abort byte when
// a packet is open and nothing otherwise; it always clears the packet counter.
// An input transaction is held in a one-entry input register and its first
// result is loaded from there into the output register, so each output
// passes through both registers. Throughput is one byte per cycle in both
// directions while out_ready stays high; the input side stalls while a
// header is produced from the held byte.
// Configuration writes take effect at once and cfg_ready is always high; write
// only while the block is idle. Reset sets the registers to their defaults,
// closes any packet and clears the counter. When out_ready is low the output
// register holds its transaction and the input register fills, after which
// in_ready drops.
module vban_audio_packetizer_top import vbanp_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_BYTES = 1436,
	parameter int unsigned MAX_FRAMES        = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);

	logic [4:0]       rate_q;
	logic [1:0]       format_q;
	logic [3:0]       chans_q;
	logic [8:0]       frames_q;
	logic [63:0]      name_low_q;
	logic [63:0]      name_high_q;

	logic             valid_s1;
	in_t              item_s1;
	logic [LEN_W-1:0] pos_q;
	logic [4:0]       hdr_q;
	logic [31:0]      cnt_q;
	logic             out_valid_q;
	out_t             out_q;

	logic [7:0]       frames_m1;
	logic [2:0]       channels_m1;
	logic [LEN_W-1:0] payload_len;
	hdr_fields_t      hdr_fields;
	logic [7:0]       hdr_byte;

	logic             out_free;
	logic             is_flush;
	logic             in_hdr;
	logic [LEN_W-1:0] pos_inc;
	logic             pkt_end;
	logic             go;
	logic             consume;
	logic             emit;
	out_t             next_out;

	vbanp_geometry #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
		.MAX_FRAMES       (MAX_FRAMES),
		.LEN_W            (LEN_W)
	) u_geometry (
		.sample_format    (format_q),
		.channel_count    (chans_q),
		.frames_per_packet(frames_q),
		.frames_m1        (frames_m1),
		.channels_m1      (channels_m1),
		.payload_len      (payload_len)
	);

	assign hdr_fields = '{
		rate_sel:      rate_q,
		frames_m1:     frames_m1,
		channels_m1:   channels_m1,
		sample_format: format_q,
		name_bytes:    {name_high_q, name_low_q},
		counter:       cnt_q
	};

	vbanp_header u_header (
		.fields  (hdr_fields),
		.idx     (hdr_q),
		.hdr_byte(hdr_byte)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= 5'd16;
			format_q    <= 2'd1;
			chans_q     <= 4'd2;
			frames_q    <= 9'd256;
			name_low_q  <= '0;
			name_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RATE_SEL: begin
					rate_q <= cfg_data[4:0];
				end
				REG_SAMPLE_FORMAT: begin
					format_q <= cfg_data[1:0];
				end
				REG_CHANNEL_COUNT: begin
					chans_q <= cfg_data[3:0];
				end
				REG_FRAMES_PER_PKT: begin
					frames_q <= cfg_data[8:0];
				end
				REG_NAME_LOW: begin
					name_low_q <= cfg_data;
				end
				REG_NAME_HIGH: begin
					name_high_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		out_free = !out_valid_q || out_ready;
		is_flush = (item_s1.op == OP_FLUSH);
		in_hdr   = !is_flush && (pos_q == '0) && (hdr_q != HDR_IDX_DONE);
		pos_inc  = pos_q + LEN_W'(1);
		pkt_end  = (pos_inc >= payload_len);
		go       = valid_s1 && out_free;
		consume  = go && !in_hdr;
		emit     = go && (in_hdr || !is_flush || (pos_q != '0));
		in_ready = !valid_s1 || consume;

		priority if (is_flush) begin
			next_out = '{out_byte: 8'h00, packet_end: 1'b0, packet_abort: 1'b1,
				run_end: 1'b1};
		end else if (in_hdr) begin
			next_out = '{out_byte: hdr_byte, packet_end: 1'b0, packet_abort: 1'b0,
				run_end: 1'b0};
		end else begin
			next_out = '{out_byte: item_s1.audio_byte, packet_end: pkt_end,
				packet_abort: 1'b0, run_end: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pos_q       <= '0;
			hdr_q       <= HDR_IDX_V;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
			if (go) begin
				priority if (is_flush) begin
					pos_q <= '0;
					hdr_q <= HDR_IDX_V;
					cnt_q <= '0;
				end else if (in_hdr) begin
					hdr_q <= hdr_q + 5'd1;
				end else begin
					hdr_q <= HDR_IDX_V;
					pos_q <= pkt_end ? '0 : pos_inc;
					if (pkt_end) begin
						cnt_q <= cnt_q + 32'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
		if (emit) begin
			out_q <= next_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef ASSERT_OFF
	a_hdr_only_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_q != HDR_IDX_V) |-> (pos_q == '0))
		else $error("Header in progress while a packet is open.");

	a_hdr_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_q != HDR_IDX_V) |-> valid_s1)
		else $error("Header in progress without a held audio byte.");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q <= HDR_IDX_DONE)
		else $error("Header position beyond the header length.");

	a_abort_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.packet_abort) |-> (out_q.run_end && !out_q.packet_end))
		else $error("Abort transaction with wrong flags.");
`endif

endmodule
